/* hw/rtl/gf2tv_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gf2tv_pkg
// Shared types and constants for the GF(2) transvection engine: operation
// and status codes, controller states and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package gf2tv_pkg;

	localparam int DATA_W      = 32;
	localparam int IDX_W       = 5;
	localparam int OP_W        = 3;
	localparam int SIZE_W      = 6;
	localparam int STAT_W      = 2;
	// active size after clamping, wide enough for the largest dimension
	localparam int N_W         = 7;
	localparam int MAX_DIM_DEF = 32;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

	typedef enum logic [OP_W-1:0] {
		OP_WR_ROW   = 3'd0,
		OP_RD_ROW   = 3'd1,
		OP_LEFT     = 3'd2,
		OP_RIGHT    = 3'd3,
		OP_WR_VEC   = 3'd4,
		OP_VEC_MULT = 3'd5,
		OP_RD_VEC   = 3'd6
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_BAD_TV  = 2'd1,
		STAT_BAD_ROW = 2'd2
	} stat_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_EXEC,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic fetch;
		logic exec;
	} cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/gf2tv_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gf2tv_ctrl
// Sequencer: takes one item, fetches the operand row, executes the
// operation and holds the result until the output transfer.
// ----------------------------------------------------------------------------
module gf2tv_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output gf2tv_pkg::cmd_t        cmd
);

	gf2tv_pkg::state_t state_q;
	gf2tv_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gf2tv_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			gf2tv_pkg::S_IDLE: begin
				if (in_valid) begin
					state_nxt = gf2tv_pkg::S_FETCH;
				end
			end
			gf2tv_pkg::S_FETCH: begin
				state_nxt = gf2tv_pkg::S_EXEC;
			end
			gf2tv_pkg::S_EXEC: begin
				state_nxt = gf2tv_pkg::S_OUT;
			end
			gf2tv_pkg::S_OUT: begin
				if (!out_stall) begin
					state_nxt = gf2tv_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = gf2tv_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		out_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			gf2tv_pkg::S_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			gf2tv_pkg::S_FETCH: begin
				cmd.fetch = 1'b1;
			end
			gf2tv_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
			end
			gf2tv_pkg::S_OUT: begin
				out_valid = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

/* hw/rtl/gf2tv_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gf2tv_dpath
// Matrix and vector storage in flip-flops, the size register, the operand
// row fetch and the row, column and vector update logic.
// ----------------------------------------------------------------------------
module gf2tv_dpath #(
	parameter int MAX_DIM = gf2tv_pkg::MAX_DIM_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire gf2tv_pkg::cmd_t               cmd,
	input  wire logic                          cfg_we,
	input  wire logic [gf2tv_pkg::SIZE_W-1:0]  cfg_size,
	input  wire logic [gf2tv_pkg::OP_W-1:0]    op,
	input  wire logic [gf2tv_pkg::IDX_W-1:0]   row_sel,
	input  wire logic [gf2tv_pkg::IDX_W-1:0]   col_index,
	input  wire logic [gf2tv_pkg::DATA_W-1:0]  data_in,
	output logic [gf2tv_pkg::DATA_W-1:0]       data_out,
	output logic [gf2tv_pkg::STAT_W-1:0]       status
);

	localparam int DW   = gf2tv_pkg::DATA_W;
	localparam int NW   = gf2tv_pkg::N_W;
	localparam int IW   = gf2tv_pkg::IDX_W;
	// indices are five bits wide, so no more than DATA_W rows are reachable
	localparam int ROWS = (MAX_DIM < DW) ? MAX_DIM : DW;
	localparam logic [NW-1:0] MAX_N = NW'(MAX_DIM);

	logic [gf2tv_pkg::OP_W-1:0]   op_q;
	logic [IW-1:0]                ri_q;
	logic [IW-1:0]                ci_q;
	logic [ROWS-1:0]              din_q;
	logic [gf2tv_pkg::SIZE_W-1:0] size_q;
	logic [ROWS-1:0]              fetch_q;
	logic [ROWS-1:0]              data_q;
	gf2tv_pkg::stat_t             status_q;
	logic [ROWS-1:0]              rows_q [ROWS];
	logic [ROWS-1:0]              vec_q;

	logic [NW-1:0]        n;
	logic [ROWS-1:0]      mask;
	logic [ROWS-1:0]      ri_oh;
	logic [ROWS-1:0]      ci_oh;
	logic                 ri_ok;
	logic                 ci_ok;
	logic                 tv_ok;
	logic [IW-1:0]        fetch_addr;
	logic [ROWS-1:0]      fetch_row;
	logic [ROWS-1:0]      vec_new;
	logic [ROWS-1:0]      data_nxt;
	gf2tv_pkg::stat_t     status_nxt;
	logic                 row_wr;
	logic                 row_add;
	logic                 col_flip;
	logic                 vec_wr;
	logic                 vec_flip;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			ri_q  <= row_sel;
			ci_q  <= col_index;
			din_q <= data_in[ROWS-1:0];
		end
		if (cmd.fetch) begin
			fetch_q <= fetch_row;
		end
		if (cmd.exec) begin
			data_q <= data_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= gf2tv_pkg::SIZE_RESET;
			status_q <= gf2tv_pkg::STAT_OK;
			vec_q    <= '0;
		end else begin
			if (cfg_we) begin
				size_q <= cfg_size;
			end
			if (cmd.exec) begin
				status_q <= status_nxt;
				if (vec_wr) begin
					vec_q <= din_q & mask;
				end else if (vec_flip) begin
					vec_q <= vec_new;
				end
			end
		end
	end

	// active size clamped to the matrix dimension
	always_comb begin
		n = ({1'b0, size_q} > MAX_N) ? MAX_N : {1'b0, size_q};
		for (int k = 0; k < ROWS; k++) begin
			mask[k]  = NW'(k) < n;
			ri_oh[k] = ri_q == IW'(k);
			ci_oh[k] = ci_q == IW'(k);
		end
		ri_ok = {2'b00, ri_q} < n;
		ci_ok = {2'b00, ci_q} < n;
		tv_ok = ri_ok && ci_ok && (ri_q != ci_q);
	end

	// left multiply needs the source row, a row read needs the addressed row
	always_comb begin
		fetch_addr = (op_q == gf2tv_pkg::OP_LEFT) ? ci_q : ri_q;
		fetch_row  = '0;
		for (int r = 0; r < ROWS; r++) begin
			if (fetch_addr == IW'(r)) begin
				fetch_row = rows_q[r];
			end
		end
	end

	assign vec_new = (|(vec_q & ci_oh)) ? (vec_q ^ ri_oh) : vec_q;

	always_comb begin
		data_nxt   = '0;
		status_nxt = gf2tv_pkg::STAT_OK;
		row_wr     = 1'b0;
		row_add    = 1'b0;
		col_flip   = 1'b0;
		vec_wr     = 1'b0;
		vec_flip   = 1'b0;
		case (op_q)
			gf2tv_pkg::OP_WR_ROW: begin
				if (ri_ok) begin
					row_wr = 1'b1;
				end else begin
					status_nxt = gf2tv_pkg::STAT_BAD_ROW;
				end
			end
			gf2tv_pkg::OP_RD_ROW: begin
				if (ri_ok) begin
					data_nxt = fetch_q & mask;
				end else begin
					status_nxt = gf2tv_pkg::STAT_BAD_ROW;
				end
			end
			gf2tv_pkg::OP_LEFT: begin
				if (tv_ok) begin
					row_add = 1'b1;
				end else begin
					status_nxt = gf2tv_pkg::STAT_BAD_TV;
				end
			end
			gf2tv_pkg::OP_RIGHT: begin
				if (tv_ok) begin
					col_flip = 1'b1;
				end else begin
					status_nxt = gf2tv_pkg::STAT_BAD_TV;
				end
			end
			gf2tv_pkg::OP_WR_VEC: begin
				vec_wr = 1'b1;
			end
			gf2tv_pkg::OP_VEC_MULT: begin
				if (tv_ok) begin
					vec_flip = 1'b1;
					data_nxt = vec_new & mask;
				end else begin
					status_nxt = gf2tv_pkg::STAT_BAD_TV;
				end
			end
			gf2tv_pkg::OP_RD_VEC: begin
				data_nxt = vec_q & mask;
			end
			default: begin
				data_nxt = '0;
			end
		endcase
	end

	for (genvar r = 0; r < ROWS; r++) begin : g_row
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rows_q[r] <= '0;
			end else if (cmd.exec) begin
				if (row_wr && ri_oh[r]) begin
					rows_q[r] <= din_q & mask;
				end else if (row_add && ri_oh[r]) begin
					rows_q[r] <= rows_q[r] ^ (fetch_q & mask);
				end else if (col_flip && mask[r] && (|(rows_q[r] & ri_oh))) begin
					// column ci picks up column ri in every active row
					rows_q[r] <= rows_q[r] ^ ci_oh;
				end
			end
		end
	end

	assign data_out = DW'(data_q);
	assign status   = status_q;

endmodule
`default_nettype wire

/* hw/rtl/gf2_transvection_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gf2_transvection_engine
// Bit matrix and bit vector over GF(2) with row and vector access and
// left, right and vector transvections, one operation per input item.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  op, row_sel, col_index, data_in
//   out      out_valid/out_stall  data_out, status
//   cfg      cfg_valid/cfg_ready  size_in_use
//
// every item passes through load, operand row fetch, execute and result
// presented, set by the controller sequence, and stays presented while the
// output is stalled; the next item is taken in the cycle after the output transfer.
// reset clears the matrix and the vector at once and sets the size to 32.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module gf2_transvection_engine #(
	parameter int MAX_DIM = gf2tv_pkg::MAX_DIM_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [gf2tv_pkg::OP_W-1:0]    op,
	input  wire logic [gf2tv_pkg::IDX_W-1:0]   row_sel,
	input  wire logic [gf2tv_pkg::IDX_W-1:0]   col_index,
	input  wire logic [gf2tv_pkg::DATA_W-1:0]  data_in,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [gf2tv_pkg::DATA_W-1:0]       data_out,
	output logic [gf2tv_pkg::STAT_W-1:0]       status,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [gf2tv_pkg::SIZE_W-1:0]  size_in_use
);

	gf2tv_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	gf2tv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	gf2tv_dpath #(
		.MAX_DIM (MAX_DIM)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_size  (size_in_use),
		.op        (op),
		.row_sel   (row_sel),
		.col_index (col_index),
		.data_in   (data_in),
		.data_out  (data_out),
		.status    (status)
	);

endmodule
`default_nettype wire
